// File: rtl/ifmt_pkg.sv
// ----------------------------------------------------------------------------
// ifmt_pkg
// Shared types, constants and helpers of the integer field formatter.
// ----------------------------------------------------------------------------
package ifmt_pkg;

  // Field geometry
  localparam int VAL_W     = 32;                 // argument width
  localparam int FW_W      = 6;                  // field width port
  localparam int MAX_WIDTH = 32;                 // width saturation point
  localparam int DIG_W     = 4;                  // one digit slot
  localparam int MAX_DIG   = 32;                 // longest digit string (binary)
  localparam int DREG_W    = MAX_DIG * DIG_W;    // digit shift register
  localparam int DEC_DIG   = 10;                 // decimal digits of 32 bits
  localparam int BCD_W     = DEC_DIG * DIG_W;
  localparam int HEX_DIG   = VAL_W / DIG_W;
  localparam int NDIG_W    = $clog2(MAX_DIG + 1);
  localparam int CNT_W     = $clog2(VAL_W);

  // ASCII codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_UPA   = 8'h41;

  // Field kinds
  typedef enum logic [1:0] {
    KIND_DEC = 2'd0,
    KIND_HEX = 2'd1,
    KIND_BIN = 2'd2,
    KIND_CHR = 2'd3
  } kind_t;

  // Latched request as seen by the character sequencer
  typedef struct packed {
    kind_t           kind;
    logic [7:0]      chr;
    logic            neg;
    logic [FW_W-1:0] fw;
    logic            zpad;
    logic            left;
  } req_t;

  // Status of the digit unit
  typedef struct packed {
    logic              rdy;
    logic [NDIG_W-1:0] ndig;
    logic [DIG_W-1:0]  top;
  } dig_stat_t;

  // Map a digit value to its ASCII character, 0-9 then A-F
  function automatic logic [7:0] digit_ascii(input logic [DIG_W-1:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'b0, d};
    end else begin
      c = CH_UPA + {4'b0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

// File: rtl/integer_to_ascii_formatter.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Formats one printf-style integer or character field per item and emits
// its ASCII characters, first character first, one per cycle.
// ----------------------------------------------------------------------------
//  Channel  Handshake              Payload
//  in_      start && !busy         req_type, value, field_width, zero_fill,
//                                  flush_left
//  out_     out_valid, one cycle   char_code, last_char
//
//  Steps: the item is registered, then the digit unit runs bit-serial BCD
//  conversion for decimal, then drops leading zero digits (up to 9 decimal,
//  7 hex, 31 binary); then a planning step; then one character per cycle,
//  max(width, text length) characters.
//  Character fields skip the digit unit. busy covers the whole item.
//  Reset is synchronous and clears control state only.
//  The receiver cannot stall: every result shows for exactly one cycle.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter
  import ifmt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       in_req_type,
  input  logic [VAL_W-1:0] in_value,
  input  logic [FW_W-1:0]  in_field_width,
  input  logic             in_zero_fill,
  input  logic             in_flush_left,
  output logic             out_valid,
  output logic [7:0]       out_char_code,
  output logic             out_last_char
);

  logic             load_r;
  kind_t            kind_r;
  logic [VAL_W-1:0] val_r;
  logic [FW_W-1:0]  fw_r;
  logic             zpad_r;
  logic             left_r;
  logic             accept;
  logic             e_busy;
  logic             shift;
  req_t             req;
  dig_stat_t        dig;

  assign accept = start && !busy;
  assign busy   = load_r || e_busy;

  // Latch the item, saturating the field width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_r <= 1'b0;
    end else begin
      load_r <= accept;
    end
    if (accept) begin
      kind_r <= kind_t'(in_req_type);
      val_r  <= in_value;
      fw_r   <= (in_field_width > FW_W'(MAX_WIDTH)) ? FW_W'(MAX_WIDTH) : in_field_width;
      zpad_r <= in_zero_fill;
      left_r <= in_flush_left;
    end
  end

  // Character fields pad with spaces only
  assign req.kind = kind_r;
  assign req.chr  = val_r[7:0];
  assign req.neg  = (kind_r == KIND_DEC) && val_r[VAL_W-1];
  assign req.fw   = fw_r;
  assign req.zpad = zpad_r && (kind_r != KIND_CHR);
  assign req.left = left_r;

  ifmt_digits u_digits (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (load_r),
    .kind  (kind_r),
    .value (val_r),
    .shift (shift),
    .stat  (dig)
  );

  ifmt_emit u_emit (
    .clk           (clk),
    .rst_n         (rst_n),
    .go            (load_r),
    .req           (req),
    .dig           (dig),
    .shift         (shift),
    .busy          (e_busy),
    .out_valid     (out_valid),
    .out_char_code (out_char_code),
    .out_last_char (out_last_char)
  );

  // An accepted item keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy not raised after accept");

  // The last character is never directly followed by another
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_char |=> !out_valid)
    else $error("result right after last character");

  // Busy only drops together with the last character of the field
  a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(busy) |-> out_valid && out_last_char)
    else $error("busy dropped without last character");

endmodule

// File: rtl/ifmt_digits.sv
// ----------------------------------------------------------------------------
// ifmt_digits
// Digit unit: bit-serial binary to BCD conversion, leading zero strip and a
// digit shift register that hands out one digit per shift, top first.
// ----------------------------------------------------------------------------
module ifmt_digits
  import ifmt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  kind_t            kind,
  input  logic [VAL_W-1:0] value,
  input  logic             shift,
  output dig_stat_t        stat
);

  typedef enum logic [1:0] {D_IDLE, D_CONV, D_STRIP, D_HOLD} dstate_t;

  dstate_t           state_r, state_nxt;
  logic [DREG_W-1:0] dig_r, dig_nxt;
  logic [VAL_W-1:0]  mag_r, mag_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [NDIG_W-1:0] ndig_r, ndig_nxt;

  logic [BCD_W-1:0]  bcd_adj;
  logic [DREG_W-1:0] bin_exp;
  logic [DIG_W-1:0]  top_dig;

  assign top_dig = dig_r[DREG_W-1 -: DIG_W];

  // Add three to every BCD digit of five or more before the shift
  always_comb begin
    for (int k = 0; k < DEC_DIG; k++) begin
      if (dig_r[DREG_W-BCD_W+k*DIG_W +: DIG_W] >= 4'd5) begin
        bcd_adj[k*DIG_W +: DIG_W] = dig_r[DREG_W-BCD_W+k*DIG_W +: DIG_W] + 4'd3;
      end else begin
        bcd_adj[k*DIG_W +: DIG_W] = dig_r[DREG_W-BCD_W+k*DIG_W +: DIG_W];
      end
    end
  end

  // Spread the argument bits into one digit slot each
  always_comb begin
    for (int i = 0; i < VAL_W; i++) begin
      bin_exp[DREG_W-1-i*DIG_W -: DIG_W] = {3'b0, value[VAL_W-1-i]};
    end
  end

  // Next state of the digit unit
  always_comb begin
    state_nxt = state_r;
    dig_nxt   = dig_r;
    mag_nxt   = mag_r;
    cnt_nxt   = cnt_r;
    ndig_nxt  = ndig_r;
    if (load) begin
      unique case (kind)
        KIND_DEC: begin
          state_nxt = D_CONV;
          dig_nxt   = '0;
          mag_nxt   = value[VAL_W-1] ? (VAL_W'(0) - value) : value;
          cnt_nxt   = CNT_W'(VAL_W - 1);
          ndig_nxt  = NDIG_W'(DEC_DIG);
        end
        KIND_HEX: begin
          state_nxt = D_STRIP;
          dig_nxt   = {value, (DREG_W-VAL_W)'(0)};
          ndig_nxt  = NDIG_W'(HEX_DIG);
        end
        KIND_BIN: begin
          state_nxt = D_STRIP;
          dig_nxt   = bin_exp;
          ndig_nxt  = NDIG_W'(MAX_DIG);
        end
        default: begin
          state_nxt = D_IDLE;
        end
      endcase
    end else begin
      unique case (state_r)
        D_IDLE: begin
          state_nxt = D_IDLE;
        end
        // shift one magnitude bit into the BCD digits
        D_CONV: begin
          dig_nxt = {bcd_adj[BCD_W-2:0], mag_r[VAL_W-1], (DREG_W-BCD_W)'(0)};
          mag_nxt = {mag_r[VAL_W-2:0], 1'b0};
          cnt_nxt = cnt_r - CNT_W'(1);
          if (cnt_r == '0) begin
            state_nxt = D_STRIP;
          end
        end
        // drop one leading zero digit, keep at least one
        D_STRIP: begin
          if (top_dig == '0 && ndig_r > NDIG_W'(1)) begin
            dig_nxt  = {dig_r[DREG_W-DIG_W-1:0], (DIG_W)'(0)};
            ndig_nxt = ndig_r - NDIG_W'(1);
          end else begin
            state_nxt = D_HOLD;
          end
        end
        // hand out digits on request
        D_HOLD: begin
          if (shift) begin
            dig_nxt = {dig_r[DREG_W-DIG_W-1:0], (DIG_W)'(0)};
          end
        end
        default: begin
          state_nxt = D_IDLE;
        end
      endcase
    end
  end

  // Hold state and digit registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    dig_r  <= dig_nxt;
    mag_r  <= mag_nxt;
    cnt_r  <= cnt_nxt;
    ndig_r <= ndig_nxt;
  end

  assign stat.rdy  = (state_r == D_HOLD);
  assign stat.ndig = ndig_r;
  assign stat.top  = top_dig;

endmodule

// File: rtl/ifmt_emit.sv
// ----------------------------------------------------------------------------
// ifmt_emit
// Character sequencer: walks sign and leading padding (in either order), text
// and trailing padding, one character per cycle, into registered result ports.
// ----------------------------------------------------------------------------
module ifmt_emit
  import ifmt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       go,
  input  req_t       req,
  input  dig_stat_t  dig,
  output logic       shift,
  output logic       busy,
  output logic       out_valid,
  output logic [7:0] out_char_code,
  output logic       out_last_char
);

  typedef enum logic [2:0] {
    E_IDLE, E_WAIT, E_SIGN_A, E_PAD, E_SIGN_B, E_TEXT, E_TPAD
  } estate_t;

  estate_t           state_r, state_nxt;
  logic [FW_W-1:0]   pad_cnt_r, pad_cnt_nxt;
  logic [NDIG_W-1:0] txt_cnt_r, txt_cnt_nxt;
  logic              pad_l_r, pad_l_nxt;
  logic              sign_b_r, sign_b_nxt;
  logic              tpad_r, tpad_nxt;
  logic [7:0]        padch_r, padch_nxt;
  logic              valid_r, valid_nxt;
  logic [7:0]        char_r, char_nxt;
  logic              last_r, last_nxt;

  logic              is_chr;
  logic [FW_W-1:0]   len;
  logic [FW_W-1:0]   pad;
  logic [7:0]        text_ch;

  assign is_chr  = (req.kind == KIND_CHR);
  assign text_ch = is_chr ? req.chr : digit_ascii(dig.top);

  // Text length and padding count
  always_comb begin
    if (is_chr) begin
      len = FW_W'(1);
    end else begin
      len = FW_W'(dig.ndig) + FW_W'(req.neg);
    end
    pad = (req.fw > len) ? (req.fw - len) : '0;
  end

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    pad_cnt_nxt = pad_cnt_r;
    txt_cnt_nxt = txt_cnt_r;
    pad_l_nxt   = pad_l_r;
    sign_b_nxt  = sign_b_r;
    tpad_nxt    = tpad_r;
    padch_nxt   = padch_r;
    valid_nxt   = 1'b0;
    char_nxt    = char_r;
    last_nxt    = 1'b0;
    shift       = 1'b0;
    unique case (state_r)
      E_IDLE: begin
        if (go) begin
          state_nxt = E_WAIT;
        end
      end
      // plan the segments once the digits are ready
      E_WAIT: begin
        if (is_chr || dig.rdy) begin
          pad_cnt_nxt = pad;
          txt_cnt_nxt = is_chr ? NDIG_W'(1) : dig.ndig;
          pad_l_nxt   = !req.left && (pad != '0);
          sign_b_nxt  = req.neg && !req.left && !req.zpad;
          tpad_nxt    = req.left && (pad != '0);
          padch_nxt   = (req.zpad && !req.left) ? CH_ZERO : CH_SPACE;
          if (req.neg && (req.left || req.zpad)) begin
            state_nxt = E_SIGN_A;
          end else if (!req.left && (pad != '0)) begin
            state_nxt = E_PAD;
          end else if (req.neg) begin
            state_nxt = E_SIGN_B;
          end else begin
            state_nxt = E_TEXT;
          end
        end
      end
      // sign ahead of zero padding or left-aligned text
      E_SIGN_A: begin
        valid_nxt = 1'b1;
        char_nxt  = CH_MINUS;
        state_nxt = pad_l_r ? E_PAD : E_TEXT;
      end
      E_PAD: begin
        valid_nxt   = 1'b1;
        char_nxt    = padch_r;
        pad_cnt_nxt = pad_cnt_r - FW_W'(1);
        if (pad_cnt_r == FW_W'(1)) begin
          state_nxt = sign_b_r ? E_SIGN_B : E_TEXT;
        end
      end
      // sign after space padding
      E_SIGN_B: begin
        valid_nxt = 1'b1;
        char_nxt  = CH_MINUS;
        state_nxt = E_TEXT;
      end
      E_TEXT: begin
        valid_nxt   = 1'b1;
        char_nxt    = text_ch;
        shift       = !is_chr;
        txt_cnt_nxt = txt_cnt_r - NDIG_W'(1);
        if (txt_cnt_r == NDIG_W'(1)) begin
          last_nxt  = !tpad_r;
          state_nxt = tpad_r ? E_TPAD : E_IDLE;
        end
      end
      E_TPAD: begin
        valid_nxt   = 1'b1;
        char_nxt    = CH_SPACE;
        pad_cnt_nxt = pad_cnt_r - FW_W'(1);
        if (pad_cnt_r == FW_W'(1)) begin
          last_nxt  = 1'b1;
          state_nxt = E_IDLE;
        end
      end
      default: begin
        state_nxt = E_IDLE;
      end
    endcase
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= E_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
    pad_cnt_r <= pad_cnt_nxt;
    txt_cnt_r <= txt_cnt_nxt;
    pad_l_r   <= pad_l_nxt;
    sign_b_r  <= sign_b_nxt;
    tpad_r    <= tpad_nxt;
    padch_r   <= padch_nxt;
    char_r    <= char_nxt;
    last_r    <= last_nxt;
  end

  assign busy          = (state_r != E_IDLE);
  assign out_valid     = valid_r;
  assign out_char_code = char_r;
  assign out_last_char = last_r;

  // Number text is only read out once the digit unit holds it
  a_text_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == E_TEXT) && !is_chr |-> dig.rdy)
    else $error("text read before digits ready");

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the integer field formatter. A driver feeds
// printf-style fields from a queue of pending items and a monitor checks
// every emitted character and its last-character flag against a predicted
// stream, in order.
// ----------------------------------------------------------------------------
module tb_top
  import ifmt_pkg::*;
();

  localparam int RANDOM_ITEMS = 260;
  localparam int STALL_LIMIT  = 2000;  // cycles with no item or character
  localparam int TAIL_CYCLES  = 80;    // idle wait at the end of the run

  // One field as it goes into the block
  typedef struct {
    kind_t             kind;
    logic [VAL_W-1:0]  value;
    logic [FW_W-1:0]   width;
    logic              zpad;
    logic              left;
    bit                drain;  // hold off until the character stream is empty
  } field_t;

  // One character as it comes out
  typedef struct {
    logic [7:0] code;
    logic       last;
  } char_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [1:0]       in_req_type = '0;
  logic [VAL_W-1:0] in_value = '0;
  logic [FW_W-1:0]  in_field_width = '0;
  logic             in_zero_fill = 1'b0;
  logic             in_flush_left = 1'b0;
  logic             out_valid;
  logic [7:0]       out_char_code;
  logic             out_last_char;

  field_t pending_fields [$];
  char_t  expected_chars [$];
  int     errors = 0;
  int     fields_sent = 0;
  int     stall_cycles = 0;
  logic   item_taken = 1'b0;

  integer_to_ascii_formatter dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_value       (in_value),
    .in_field_width (in_field_width),
    .in_zero_fill   (in_zero_fill),
    .in_flush_left  (in_flush_left),
    .out_valid      (out_valid),
    .out_char_code  (out_char_code),
    .out_last_char  (out_last_char)
  );

  always #1 clk = ~clk;

  // Work out the characters of one field and append them to the stream
  function automatic void predict_field(field_t f);
    logic [FW_W-1:0]  fw;
    logic [VAL_W-1:0] mag;
    logic [VAL_W-1:0] base;
    logic [3:0]       digs [32];
    logic [3:0]       d;
    logic             neg;
    logic [7:0]       text [$];
    int               ndig;
    int               len;
    int               pad;
    fw = (f.width > FW_W'(MAX_WIDTH)) ? FW_W'(MAX_WIDTH) : f.width;
    if (f.kind == KIND_CHR) begin
      pad = (fw > 1) ? int'(fw) - 1 : 0;
      if (!f.left) repeat (pad) text.push_back(CH_SPACE);
      text.push_back(f.value[7:0]);
      if (f.left) repeat (pad) text.push_back(CH_SPACE);
    end else begin
      neg  = (f.kind == KIND_DEC) && f.value[VAL_W-1];
      mag  = neg ? (~f.value + 1'b1) : f.value;
      base = (f.kind == KIND_DEC) ? 10 : (f.kind == KIND_HEX) ? 16 : 2;
      ndig = 0;
      // split into digits, least significant first
      do begin
        digs[ndig] = 4'(mag % base);
        mag = mag / base;
        ndig++;
      end while (mag != 0 && ndig < 32);
      len = ndig + int'(neg);
      pad = (int'(fw) > len) ? int'(fw) - len : 0;
      if (!f.left && f.zpad) begin
        // sign ahead of the zero padding
        if (neg) text.push_back(CH_MINUS);
        repeat (pad) text.push_back(CH_ZERO);
      end else if (!f.left) begin
        repeat (pad) text.push_back(CH_SPACE);
        if (neg) text.push_back(CH_MINUS);
      end else if (neg) begin
        text.push_back(CH_MINUS);
      end
      for (int i = ndig - 1; i >= 0; i--) begin
        d = digs[i];
        text.push_back((d < 4'd10) ? 8'(CH_ZERO + d) : 8'(CH_UPA + d - 8'd10));
      end
      if (f.left) repeat (pad) text.push_back(CH_SPACE);
    end
    foreach (text[i]) expected_chars.push_back('{text[i], i == text.size() - 1});
  endfunction

  task automatic add_field(kind_t k, logic [VAL_W-1:0] v, logic [FW_W-1:0] w,
                           logic z, logic l, bit dr);
    field_t f;
    f = '{k, v, w, z, l, dr};
    pending_fields.push_back(f);
  endtask

  // Driver: hold an item until taken, then offer the next or idle
  always @(negedge clk) begin : drive_fields
    int idle_pct;
    field_t f;
    idle_pct = (fields_sent < 95) ? 36 : (fields_sent < 190) ? 66 : 0;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && !item_taken)) begin
      if (pending_fields.size() != 0 &&
          !(pending_fields[0].drain && expected_chars.size() != 0) &&
          $urandom_range(0, 99) >= idle_pct) begin
        f = pending_fields.pop_front();
        start          <= 1'b1;
        in_req_type    <= f.kind;
        in_value       <= f.value;
        in_field_width <= f.width;
        in_zero_fill   <= f.zpad;
        in_flush_left  <= f.left;
        fields_sent++;
      end else begin
        // idle: scramble the payload, the block must ignore it
        start          <= 1'b0;
        in_req_type    <= 2'($urandom());
        in_value       <= $urandom();
        in_field_width <= FW_W'($urandom());
        in_zero_fill   <= 1'($urandom());
        in_flush_left  <= 1'($urandom());
      end
    end
  end

  // Take items at the rising edge and predict their characters
  always @(posedge clk) begin : take_fields
    field_t f;
    if (rst_n && start && !busy) begin
      f = '{kind_t'(in_req_type), in_value, in_field_width, in_zero_fill,
            in_flush_left, 1'b0};
      predict_field(f);
      item_taken <= 1'b1;
    end else begin
      item_taken <= 1'b0;
    end
  end

  // Monitor: compare each character with the oldest prediction
  always @(posedge clk) begin : check_chars
    char_t want;
    if (rst_n && out_valid) begin
      if (expected_chars.size() == 0) begin
        $error("unexpected character: char_code %02h last_char %0b",
               out_char_code, out_last_char);
        errors++;
      end else begin
        want = expected_chars.pop_front();
        if (out_char_code !== want.code) begin
          $error("char_code: expected %02h, got %02h", want.code, out_char_code);
          errors++;
        end
        if (out_last_char !== want.last) begin
          $error("last_char: expected %0b, got %0b", want.last, out_last_char);
          errors++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("FAIL integer_to_ascii_formatter");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    kind_t            k;
    logic [VAL_W-1:0] v;
    logic [FW_W-1:0]  w;

    // directed: extremes, every kind, sign and padding corners
    add_field(KIND_DEC, 32'd0,          6'd0,  1'b0, 1'b0, 1'b0);
    add_field(KIND_DEC, 32'h8000_0000,  6'd0,  1'b0, 1'b0, 1'b0);
    add_field(KIND_DEC, 32'h7FFF_FFFF,  6'd0,  1'b0, 1'b0, 1'b0);
    add_field(KIND_DEC, 32'hFFFF_FFFF,  6'd0,  1'b0, 1'b0, 1'b0);
    add_field(KIND_DEC, -32'sd42,       6'd8,  1'b1, 1'b0, 1'b0);
    add_field(KIND_DEC, -32'sd42,       6'd8,  1'b0, 1'b0, 1'b0);
    add_field(KIND_DEC, -32'sd42,       6'd8,  1'b1, 1'b1, 1'b0);
    add_field(KIND_DEC, 32'd12345,      6'd33, 1'b0, 1'b1, 1'b0);
    add_field(KIND_DEC, 32'd1,          6'd1,  1'b1, 1'b0, 1'b0);
    add_field(KIND_DEC, 32'h8000_0000,  6'd32, 1'b1, 1'b0, 1'b1);
    add_field(KIND_HEX, 32'hDEAD_BEEF,  6'd0,  1'b0, 1'b0, 1'b0);
    add_field(KIND_HEX, 32'd0,          6'd63, 1'b1, 1'b0, 1'b0);
    add_field(KIND_HEX, 32'hFFFF_FFFF,  6'd32, 1'b0, 1'b1, 1'b0);
    add_field(KIND_HEX, 32'h0ABC_DEF0,  6'd10, 1'b1, 1'b0, 1'b0);
    add_field(KIND_BIN, 32'hFFFF_FFFF,  6'd0,  1'b0, 1'b0, 1'b0);
    add_field(KIND_BIN, 32'd0,          6'd5,  1'b1, 1'b0, 1'b0);
    add_field(KIND_BIN, 32'h8000_0000,  6'd40, 1'b0, 1'b0, 1'b0);
    add_field(KIND_BIN, 32'h0000_0005,  6'd6,  1'b1, 1'b1, 1'b0);
    add_field(KIND_CHR, 32'h0000_0041,  6'd0,  1'b0, 1'b0, 1'b0);
    add_field(KIND_CHR, 32'hFFFF_FF00,  6'd5,  1'b1, 1'b0, 1'b0);
    add_field(KIND_CHR, 32'h0000_00FF,  6'd32, 1'b0, 1'b1, 1'b0);
    add_field(KIND_CHR, 32'h0000_007A,  6'd63, 1'b1, 1'b1, 1'b0);
    add_field(KIND_CHR, 32'h1234_5630,  6'd1,  1'b0, 1'b0, 1'b0);

    // random fields, mostly narrow widths and a spread of magnitudes
    repeat (RANDOM_ITEMS) begin
      k = kind_t'($urandom_range(0, 3));
      case ($urandom_range(0, 5))
        0:       v = $urandom_range(0, 20);
        1:       v = -$urandom_range(1, 1000);
        2:       v = ($urandom_range(0, 1) != 0) ? 32'h8000_0000 :
                     ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'hFFFF_FFFF;
        3:       v = $urandom() >> $urandom_range(0, 31);
        default: v = $urandom();
      endcase
      w = ($urandom_range(0, 7) == 0) ? FW_W'($urandom_range(0, 63)) :
                                        FW_W'($urandom_range(0, 12));
      add_field(k, v, w, 1'($urandom()), 1'($urandom()), $urandom_range(0, 29) == 0);
    end

    // hold reset, release on a falling edge
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // wait for every item to be taken and every character to arrive
    while (pending_fields.size() != 0 || start) @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    @(negedge clk);

    if (errors == 0 && expected_chars.size() == 0) begin
      $display("PASS integer_to_ascii_formatter");
    end else begin
      $display("FAIL integer_to_ascii_formatter");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/ifmt_pkg.sv
rtl/ifmt_digits.sv
rtl/ifmt_emit.sv
rtl/integer_to_ascii_formatter.sv
test/tb_top.sv
